// ===== design/brlt_pkg.sv =====
// ----------------------------------------------------------------------------
// brlt_pkg: shared types and constants of the byte-range lock table
// Request and response structs, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package brlt_pkg;
   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam logic [1:0] OP_ACQUIRE = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_TEST    = 2'd2;

   localparam logic [1:0] LT_SHARED    = 2'd0;
   localparam logic [1:0] LT_EXCLUSIVE = 2'd1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_CONFLICT = 2'd1;
   localparam logic [1:0] ST_INVALID  = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] FT_NONE      = 2'd0;
   localparam logic [1:0] FT_SHARED    = 2'd1;
   localparam logic [1:0] FT_EXCLUSIVE = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [1:0]  lock_type;
      logic [63:0] range_start;
      logic [63:0] range_length;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] found_type;
   } rsp_type;

   // entry layout in memory: exclusive flag, start, length
   localparam int ENTRY_W = 129;
endpackage
`default_nettype wire

// ===== design/brlt_ram.sv =====
// ----------------------------------------------------------------------------
// brlt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module brlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/byte_range_lock_table_core.sv =====
// ----------------------------------------------------------------------------
// byte_range_lock_table_core: byte-range shared/exclusive lock table
// Entries live in one RAM, physical slots chained newest first by position.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  req_    | in        | req_valid/stall  | brlt_pkg::req_type
//  rsp_    | out       | rsp_valid/stall  | brlt_pkg::rsp_type
//
// One request at a time. A request with a valid operation scans the n valid
// entries, one RAM read per cycle, newest first, stopping at the first hit.
// An insert moves each older entry down one slot, then writes the head; a
// release pulls each entry behind the hit up one slot, through the tail.
// The next request is taken the cycle after the response leaves.
// Reset empties the table at once through the entry count; no clearing pass.
// The response sits in a register; stall on rsp_ holds it and blocks req_.
`default_nettype none
module byte_range_lock_table_core #(
   parameter int TABLE_DEPTH = brlt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire brlt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output brlt_pkg::rsp_type      rsp_data
);
   import brlt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_DONE  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;     // address issued last cycle
   logic             rd_pend_ff, rd_pend_in;
   logic [CW-1:0]    hit_ff, hit_in;
   logic             hit_v_ff, hit_v_in;
   logic             hit_x_ff, hit_x_in;
   logic             dir_up_ff, dir_up_in;  // shift toward tail (insert)
   logic [CW-1:0]    mv_ff, mv_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_v_ff, rsp_v_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data, rd_data;

   brlt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic        e_x;
   logic [63:0] e_start, e_len, a_end, b_end;
   logic        ovl, exact, req_x;
   assign e_x     = rd_data[128];
   assign e_start = rd_data[127:64];
   assign e_len   = rd_data[63:0];
   assign a_end   = req_ff.range_start + req_ff.range_length;
   assign b_end   = e_start + e_len;
   assign ovl     = !((a_end <= e_start) || (req_ff.range_start >= b_end));
   assign exact   = (e_start == req_ff.range_start) && (e_len == req_ff.range_length);
   assign req_x   = (req_ff.lock_type == LT_EXCLUSIVE);

   logic match;
   always_comb begin
      case (req_ff.operation)
         OP_ACQUIRE: match = ovl && (e_x || req_x);
         OP_RELEASE: match = exact;
         default:    match = ovl;
      endcase
   end

   assign req_stall = !(state_ff == S_IDLE) || rsp_v_ff;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      rd_pend_in = 1'b0;
      hit_in     = hit_ff;
      hit_v_in   = hit_v_ff;
      hit_x_in   = hit_x_ff;
      dir_up_in  = dir_up_ff;
      mv_in      = mv_ff;
      rsp_in     = rsp_ff;
      rsp_v_in   = rsp_v_ff && rsp_stall;
      wr_en      = 1'b0;
      wr_addr    = mv_ff[AW-1:0];
      wr_data    = rd_data;
      rd_addr    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in   = req_data;
               hit_v_in = 1'b0;
               idx_in   = '0;
               if (count_ff != '0 && (req_data.operation == OP_ACQUIRE ||
                     req_data.operation == OP_RELEASE || req_data.operation == OP_TEST)) begin
                  rd_addr    = '0;
                  rd_pend_in = 1'b1;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_pend_ff && match) begin
               hit_v_in = 1'b1;
               hit_in   = idx_ff;
               hit_x_in = e_x;
               state_in = S_DONE;
            end else if (rd_pend_ff && (idx_ff + 1'b1) < count_ff) begin
               idx_in     = idx_ff + 1'b1;
               rd_addr    = idx_in[AW-1:0];
               rd_pend_in = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_RESP;
            rsp_in.found_type = FT_NONE;
            rsp_in.status     = ST_OK;
            case (req_ff.operation)
               OP_ACQUIRE: begin
                  if (req_ff.lock_type != LT_SHARED && req_ff.lock_type != LT_EXCLUSIVE)
                     rsp_in.status = ST_INVALID;
                  else if (hit_v_ff) rsp_in.status = ST_CONFLICT;
                  else if (count_ff == CW'(TABLE_DEPTH)) rsp_in.status = ST_FULL;
                  else begin
                     dir_up_in = 1'b1;
                     mv_in     = count_ff;
                     state_in  = S_SHIFT;
                     if (count_ff != '0) begin
                        rd_addr    = AW'(count_ff - 1'b1);
                        rd_pend_in = 1'b1;
                     end
                  end
               end
               OP_RELEASE: begin
                  if (!hit_v_ff) rsp_in.status = ST_CONFLICT;
                  else begin
                     dir_up_in = 1'b0;
                     mv_in     = hit_ff;
                     state_in  = S_SHIFT;
                     if ((hit_ff + 1'b1) < count_ff) begin
                        rd_addr    = AW'(hit_ff + 1'b1);
                        rd_pend_in = 1'b1;
                     end
                  end
               end
               OP_TEST: begin
                  if (hit_v_ff) rsp_in.found_type = hit_x_ff ? FT_EXCLUSIVE : FT_SHARED;
               end
               default: rsp_in.status = ST_INVALID;
            endcase
         end
         S_SHIFT: begin
            if (dir_up_ff) begin
               // move entry mv-1 into mv, then head gets the new lock
               wr_en = 1'b1;
               if (rd_pend_ff) begin
                  wr_data = rd_data;
                  mv_in   = mv_ff - 1'b1;
                  if (mv_in != '0) begin
                     rd_addr    = AW'(mv_in - 1'b1);
                     rd_pend_in = 1'b1;
                  end
               end else begin
                  wr_addr  = '0;
                  wr_data  = {req_x, req_ff.range_start, req_ff.range_length};
                  count_in = count_ff + 1'b1;
                  state_in = S_RESP;
               end
            end else begin
               // pull entry mv+1 into mv until the tail
               if (rd_pend_ff) begin
                  wr_en   = 1'b1;
                  wr_data = rd_data;
                  mv_in   = mv_ff + 1'b1;
                  if ((mv_in + 1'b1) < count_ff) begin
                     rd_addr    = AW'(mv_in + 1'b1);
                     rd_pend_in = 1'b1;
                  end
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            rsp_v_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
         rsp_v_ff   <= rsp_v_in;
      end
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      hit_v_ff  <= hit_v_in;
      hit_x_ff  <= hit_x_in;
      dir_up_ff <= dir_up_in;
      mv_ff     <= mv_in;
      rsp_ff    <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH)) else $error("entry count beyond depth");
   a_write_in_shift: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SHIFT)) else $error("RAM write outside shift");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (state_ff == S_IDLE)) else $error("work while response pending");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(state_ff == S_SHIFT))
      else $error("count changed outside shift");
endmodule
`default_nettype wire
